// ===== hw/rtl/tsr_pkg.sv =====
// shared types, codes and constants for the trail sample ring
package tsr_pkg;

  // coordinate and distance widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;   // magnitude of a coordinate difference
  localparam int SQ_W    = 2 * DIFF_W;    // one squared term
  localparam int DSUM_W  = SQ_W + 2;      // sum of three squared terms

  localparam int DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH   = 2;

  // register reset values
  localparam logic [6:0]  RST_MAX_SAMPLES = 7'd64;
  localparam logic [23:0] RST_LIFETIME    = 24'd65536;
  localparam logic [22:0] RST_MIN_DIST    = 23'd0;
  localparam logic [22:0] RST_TELE_DIST   = 23'h7FFFFF;

  // mode codes
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_TICK   = 3'd1;
  localparam logic [2:0] MODE_BREAK  = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_STARTED = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_MAX_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_LIFETIME    = 2'd1;
  localparam logic [1:0] CFG_MIN_DIST    = 2'd2;
  localparam logic [1:0] CFG_TELE_DIST   = 2'd3;

  typedef enum logic [2:0] {
    OP_APPEND, OP_TICK, OP_BREAK, OP_CLEAR, OP_READ, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_AP_SQ, S_AP_DECIDE, S_AP_COMMIT,
    S_EXP_CHK, S_EXP_TEST, S_RD_OUT, S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic signed [COORD_W-1:0] root_x;
    logic signed [COORD_W-1:0] root_y;
    logic signed [COORD_W-1:0] root_z;
    logic signed [COORD_W-1:0] tip_x;
    logic signed [COORD_W-1:0] tip_y;
    logic signed [COORD_W-1:0] tip_z;
    logic [23:0]               delta_time;
    logic [5:0]                read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [6:0]                sample_count;
    logic [6:0]                dropped_count;
    logic                      sample_valid;
    logic signed [COORD_W-1:0] out_root_x;
    logic signed [COORD_W-1:0] out_root_y;
    logic signed [COORD_W-1:0] out_root_z;
    logic signed [COORD_W-1:0] out_tip_x;
    logic signed [COORD_W-1:0] out_tip_y;
    logic signed [COORD_W-1:0] out_tip_z;
    logic [31:0]               sample_age;
    logic [31:0]               sample_segment;
  } out_t;

  // one stored sample
  typedef struct packed {
    logic signed [COORD_W-1:0] root_x;
    logic signed [COORD_W-1:0] root_y;
    logic signed [COORD_W-1:0] root_z;
    logic signed [COORD_W-1:0] tip_x;
    logic signed [COORD_W-1:0] tip_y;
    logic signed [COORD_W-1:0] tip_z;
    logic [31:0]               birth;
    logic [31:0]               segment;
  } ent_t;

  // one queued beat between front and back
  typedef struct packed {
    op_t op;
    in_t item;
  } qbeat_t;

endpackage

// ===== hw/rtl/tsr_front.sv =====
// front end: accepts command beats, decodes the mode and queues them
module tsr_front import tsr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  in_t    cmd,
  output logic   q_valid,
  output qbeat_t q_beat,
  input  logic   q_pop
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  qbeat_t            queue [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   count;
  logic              accept;
  op_t               op_dec;

  assign busy    = (count == QC_W'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign q_valid = (count != '0);
  assign q_beat  = queue[rd_ptr];

  // mode decode
  always_comb begin
    unique case (cmd.mode)
      MODE_APPEND: op_dec = OP_APPEND;
      MODE_TICK:   op_dec = OP_TICK;
      MODE_BREAK:  op_dec = OP_BREAK;
      MODE_CLEAR:  op_dec = OP_CLEAR;
      MODE_READ:   op_dec = OP_READ;
      default:     op_dec = OP_NOP;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= '{op: op_dec, item: cmd};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QC_W'(accept) - QC_W'(q_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH))
    else $error("queue count past depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (busy && !q_pop) |=> (count == $past(count)))
    else $error("queue grew while full");

endmodule

// ===== hw/rtl/tsr_back.sv =====
// back end: ring state, sample memory, distance check, expiry and reads
module tsr_back import tsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  qbeat_t      q_beat,
  output logic        q_pop,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  state_t state, state_next;

  // ring and register state
  logic [CNT_W-1:0] held;
  logic [PTR_W-1:0] head;
  logic [31:0]      ctime;
  logic [31:0]      seg_ctr;
  logic             fb;
  logic [CNT_W-1:0] cap;
  logic [23:0]      lifetime_r;
  logic [22:0]      min_r;
  logic [22:0]      tele_r;

  // current item
  op_t cur_op;
  in_t cur;

  // memory
  ent_t             mem [DEPTH];
  ent_t             rd_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;

  // distance datapath
  logic [3:0]        k;
  logic              va, vb;
  logic [DIFF_W-1:0] opnd;
  logic [2:0]        opnd_idx;
  logic [SQ_W-1:0]   prod;
  logic [2:0]        prod_idx;
  logic [DSUM_W-1:0] sum_r, sum_t, dmax;
  logic [SQ_W-1:0]   mn2, tp2;
  logic [DIFF_W-1:0] opnd_sel;
  logic              skip;

  // item results
  logic [1:0]       st_r;
  logic [CNT_W-1:0] drop;

  // commit path
  logic             full;
  logic [PTR_W-1:0] h1, h2, wslot;
  logic [CNT_W-1:0] c1, c2, c3, n_trim;

  logic        expire;
  logic        in_range;
  logic [31:0] age_head;

  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [6:0] ms);
    logic [CNT_W-1:0] c;
    if (ms < 7'd2) begin
      c = CNT_W'(2);
    end else if (int'(ms) > DEPTH) begin
      c = CNT_W'(DEPTH);
    end else begin
      c = CNT_W'(ms);
    end
    return c;
  endfunction

  function automatic logic [DIFF_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W+1:0] d;
    d = (COORD_W+2)'(a) - (COORD_W+2)'(b);
    return d[COORD_W+1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_range  = 32'(cur.read_index) < 32'(held);
  assign age_head  = ctime - rd_data.birth;
  assign expire    = age_head >= 32'(lifetime_r);
  assign dmax      = (sum_r > sum_t) ? sum_r : sum_t;
  assign skip      = dmax < DSUM_W'(mn2);

  // operand for the squaring step
  always_comb begin
    case (k[2:0])
      3'd0:    opnd_sel = absdiff(cur.root_x, rd_data.root_x);
      3'd1:    opnd_sel = absdiff(cur.root_y, rd_data.root_y);
      3'd2:    opnd_sel = absdiff(cur.root_z, rd_data.root_z);
      3'd3:    opnd_sel = absdiff(cur.tip_x, rd_data.tip_x);
      3'd4:    opnd_sel = absdiff(cur.tip_y, rd_data.tip_y);
      3'd5:    opnd_sel = absdiff(cur.tip_z, rd_data.tip_z);
      3'd6:    opnd_sel = DIFF_W'(min_r);
      default: opnd_sel = DIFF_W'(tele_r);
    endcase
  end

  // append placement and trim
  always_comb begin
    full   = (held == CNT_W'(DEPTH));
    h1     = full ? wrap(SUM_W'(head) + SUM_W'(1)) : head;
    c1     = full ? held - 1'b1 : held;
    wslot  = wrap(SUM_W'(h1) + SUM_W'(c1));
    c2     = c1 + 1'b1;
    n_trim = (c2 > cap) ? c2 - cap : '0;
    h2     = wrap(SUM_W'(h1) + SUM_W'(n_trim));
    c3     = (c2 > cap) ? cap : c2;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, queue pop and read port
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (cur_op)
          OP_APPEND: begin
            rd_en   = 1'b1;
            rd_addr = wrap(SUM_W'(head) + SUM_W'(held) - SUM_W'(1));
            state_next = (held != '0 && !fb) ? S_AP_SQ : S_AP_COMMIT;
          end
          OP_TICK: state_next = S_EXP_CHK;
          OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = wrap(SUM_W'(head) + SUM_W'(cur.read_index));
            state_next = in_range ? S_RD_OUT : S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_AP_SQ:     if (k == 4'd9) state_next = S_AP_DECIDE;
      S_AP_DECIDE: state_next = skip ? S_FINISH : S_AP_COMMIT;
      S_AP_COMMIT: state_next = S_FINISH;
      S_EXP_CHK: begin
        rd_en      = 1'b1;
        state_next = (held == '0) ? S_FINISH : S_EXP_TEST;
      end
      S_EXP_TEST:  state_next = expire ? S_EXP_CHK : S_FINISH;
      S_RD_OUT:    state_next = S_FINISH;
      S_FINISH:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (state == S_AP_COMMIT) begin
      mem[wslot] <= '{root_x: cur.root_x, root_y: cur.root_y, root_z: cur.root_z,
                      tip_x: cur.tip_x, tip_y: cur.tip_y, tip_z: cur.tip_z,
                      birth: ctime, segment: seg_ctr};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // squaring pipeline payload
  always_ff @(posedge clk) begin
    if (state == S_AP_SQ) begin
      opnd     <= opnd_sel;
      opnd_idx <= k[2:0];
    end
    prod     <= opnd * opnd;
    prod_idx <= opnd_idx;
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      head       <= '0;
      ctime      <= '0;
      seg_ctr    <= '0;
      fb         <= 1'b1;
      cap        <= clamp_cap(RST_MAX_SAMPLES);
      lifetime_r <= RST_LIFETIME;
      min_r      <= RST_MIN_DIST;
      tele_r     <= RST_TELE_DIST;
      va         <= 1'b0;
      vb         <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      va   <= (state == S_AP_SQ) && (k < 4'd8);
      vb   <= va;

      // register writes, trimming at once on a smaller capacity
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_SAMPLES: begin
            cap <= clamp_cap(cfg_data[6:0]);
            if (held > clamp_cap(cfg_data[6:0])) begin
              head <= wrap(SUM_W'(head) + SUM_W'(held - clamp_cap(cfg_data[6:0])));
              held <= clamp_cap(cfg_data[6:0]);
            end
          end
          CFG_LIFETIME:  lifetime_r <= cfg_data;
          CFG_MIN_DIST:  min_r      <= cfg_data[22:0];
          CFG_TELE_DIST: tele_r     <= cfg_data[22:0];
          default: ;
        endcase
      end

      // accumulate squared terms
      if (vb) begin
        case (prod_idx)
          3'd0, 3'd1, 3'd2: sum_r <= sum_r + DSUM_W'(prod);
          3'd3, 3'd4, 3'd5: sum_t <= sum_t + DSUM_W'(prod);
          3'd6:             mn2   <= prod;
          default:          tp2   <= prod;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_op <= q_beat.op;
            cur    <= q_beat.item;
          end
        end
        S_DISPATCH: begin
          st_r   <= ST_DONE;
          drop   <= '0;
          result <= '0;
          sum_r  <= '0;
          sum_t  <= '0;
          k      <= '0;
          case (cur_op)
            OP_APPEND: begin
              st_r <= ST_STARTED;
              if (held != '0 && fb) begin
                seg_ctr <= seg_ctr + 32'd1;
              end
            end
            OP_TICK:  ctime <= ctime + 32'(cur.delta_time);
            OP_BREAK: fb <= 1'b1;
            OP_CLEAR: begin
              held    <= '0;
              head    <= '0;
              seg_ctr <= '0;
              fb      <= 1'b1;
            end
            default: ;
          endcase
        end
        S_AP_SQ: k <= k + 4'd1;
        S_AP_DECIDE: begin
          if (skip) begin
            st_r <= ST_SKIPPED;
          end else if (dmax > DSUM_W'(tp2)) begin
            st_r    <= ST_STARTED;
            seg_ctr <= seg_ctr + 32'd1;
          end else begin
            st_r <= ST_ADDED;
          end
        end
        S_AP_COMMIT: begin
          head <= h2;
          held <= c3;
          drop <= CNT_W'(full) + n_trim;
          fb   <= 1'b0;
        end
        S_EXP_TEST: begin
          if (expire) begin
            head <= wrap(SUM_W'(head) + SUM_W'(1));
            held <= held - 1'b1;
            drop <= drop + 1'b1;
          end
        end
        S_RD_OUT: begin
          result.sample_valid   <= 1'b1;
          result.out_root_x     <= rd_data.root_x;
          result.out_root_y     <= rd_data.root_y;
          result.out_root_z     <= rd_data.root_z;
          result.out_tip_x      <= rd_data.tip_x;
          result.out_tip_y      <= rd_data.tip_y;
          result.out_tip_z      <= rd_data.tip_z;
          result.sample_age     <= ctime - rd_data.birth;
          result.sample_segment <= rd_data.segment;
        end
        S_FINISH: begin
          result.status        <= st_r;
          result.sample_count  <= 7'(held);
          result.dropped_count <= 7'(drop);
          done                 <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("held count past depth");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("result strobe without finish");
  a_commit_clears_break: assert property (@(posedge clk) disable iff (rst)
    (state == S_AP_COMMIT) |=> !fb)
    else $error("break flag kept after push");
  a_held_within_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && cur_op == OP_APPEND) |-> held <= cap)
    else $error("ring over capacity after append");

endmodule

// ===== hw/rtl/trail_sample_ring.sv =====
// top level of the trail sample ring
// Commands are taken with start while busy is low and land in a two-beat queue; the
// back end runs them one at a time and answers each with one result beat, shown for
// exactly one cycle under done, which cannot be held off. Out of the queue, each
// command passes a dispatch state and ends in a finish state that raises done; a
// read in range adds an output state, an append on an empty ring or after a break
// a commit state, an append with the distance check a squaring walk (one shared
// 25x25 squarer walks six coordinate terms and both thresholds), a decide state
// and, unless skipped, a commit state, and a tick a check state and, while samples
// remain, a test that loops back on expiry, since each waits on one memory read.
// Configuration writes are always ready and must only come while the block is idle.
module trail_sample_ring import tsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         cmd,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic   q_valid;
  logic   q_pop;
  qbeat_t q_beat;

  // command intake and queue
  tsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_beat  (q_beat),
    .q_pop   (q_pop)
  );

  // ring engine
  tsr_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
